@@ rtl/tlfk_pkg.sv @@
// shared constants, types and the arctangent table for the leg kinematics unit
`timescale 1ns / 1ps
package tlfk_pkg;

  // cordic iteration count and pre-compensated gain in q2.30
  localparam int unsigned CordicSteps = 30;
  localparam logic signed [32:0] CordicGain = 33'sh026DD3B6A;

  // largest reach of the three links together, 2^-16 m
  localparam int unsigned ReachMax = 196608;

  // per-step rotation angle, full turn = 2^32
  function automatic logic [31:0] atan_turn(input int unsigned idx);
    case (idx)
      0:  return 32'h20000000;
      1:  return 32'h12E4051E;
      2:  return 32'h09FB385B;
      3:  return 32'h051111D4;
      4:  return 32'h028B0D43;
      5:  return 32'h0145D7E1;
      6:  return 32'h00A2F61E;
      7:  return 32'h00517C55;
      8:  return 32'h0028BE53;
      9:  return 32'h00145F2F;
      10: return 32'h000A2F98;
      11: return 32'h000517CC;
      12: return 32'h00028BE6;
      13: return 32'h000145F3;
      14: return 32'h0000A2FA;
      15: return 32'h0000517D;
      16: return 32'h000028BE;
      17: return 32'h0000145F;
      18: return 32'h00000A30;
      19: return 32'h00000518;
      20: return 32'h0000028C;
      21: return 32'h00000146;
      22: return 32'h000000A3;
      23: return 32'h00000051;
      24: return 32'h00000029;
      25: return 32'h00000014;
      26: return 32'h0000000A;
      27: return 32'h00000005;
      28: return 32'h00000003;
      29: return 32'h00000001;
      default: return 32'h00000000;
    endcase
  endfunction

  // joint rates carried alongside the sine/cosine pipeline
  typedef struct packed {
    logic signed [15:0] hr;
    logic signed [15:0] kr;
    logic signed [15:0] ar;
  } rates_t;

  // finished position and velocity fields waiting for the slow branches
  typedef struct packed {
    logic signed [18:0] fx;
    logic signed [18:0] fy;
    logic signed [23:0] vx;
    logic signed [23:0] vy;
    logic               zero;
  } kin_t;

endpackage

@@ rtl/tlfk_sincos.sv @@
// pipelined rotation cordic giving sine and cosine of a binary angle
`timescale 1ns / 1ps
module tlfk_sincos (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [15:0]        ang_i,
  output logic signed [32:0] sin_o,
  output logic signed [32:0] cos_o
);
  import tlfk_pkg::*;

  localparam int unsigned N = CordicSteps;

  logic signed [32:0] x_q [1:N];
  logic signed [32:0] y_q [1:N];
  logic signed [31:0] z_q [1:N];
  logic [1:0]         quad_q [1:N];

  logic signed [32:0] xs [0:N-1];
  logic signed [32:0] ys [0:N-1];
  logic signed [31:0] zs [0:N-1];
  logic [1:0]         qs [0:N-1];

  // stage inputs: first from the port, the rest from the previous stage
  always_comb begin
    xs[0] = CordicGain;
    ys[0] = '0;
    zs[0] = {2'b00, ang_i[13:0], 16'h0000};
    qs[0] = ang_i[15:14];
    for (int i = 1; i < N; i++) begin
      xs[i] = x_q[i];
      ys[i] = y_q[i];
      zs[i] = z_q[i];
      qs[i] = quad_q[i];
    end
  end

  // one micro-rotation per stage
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < N; i++) begin
        quad_q[i+1] <= qs[i];
        if (zs[i] >= 0) begin
          x_q[i+1] <= xs[i] - (ys[i] >>> i);
          y_q[i+1] <= ys[i] + (xs[i] >>> i);
          z_q[i+1] <= zs[i] - $signed(atan_turn(i));
        end else begin
          x_q[i+1] <= xs[i] + (ys[i] >>> i);
          y_q[i+1] <= ys[i] - (xs[i] >>> i);
          z_q[i+1] <= zs[i] + $signed(atan_turn(i));
        end
      end
    end
  end

  // quadrant fix-up
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      case (quad_q[N])
        2'd0: begin cos_o <= x_q[N];  sin_o <= y_q[N];  end
        2'd1: begin cos_o <= -y_q[N]; sin_o <= x_q[N];  end
        2'd2: begin cos_o <= -x_q[N]; sin_o <= -y_q[N]; end
        default: begin cos_o <= y_q[N]; sin_o <= -x_q[N]; end
      endcase
    end
  end

endmodule

@@ rtl/tlfk_vector.sv @@
// pipelined vectoring cordic giving the binary angle of a vector
`timescale 1ns / 1ps
module tlfk_vector (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [19:0] cos_i,
  input  logic signed [19:0] sin_i,
  output logic [31:0]        ang_o
);
  import tlfk_pkg::*;

  localparam int unsigned N = CordicSteps;

  logic signed [37:0] cx_q [0:N];
  logic signed [37:0] sy_q [0:N];
  logic [31:0]        z_q  [0:N];

  logic signed [37:0] cx_pre;
  logic signed [37:0] sy_pre;

  // scale by 2^16 and fold the left half-plane
  always_comb begin
    cx_pre = {{2{cos_i[19]}}, cos_i, 16'h0000};
    sy_pre = {{2{sin_i[19]}}, sin_i, 16'h0000};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (cx_pre < 0) begin
        cx_q[0] <= -cx_pre;
        sy_q[0] <= -sy_pre;
        z_q[0]  <= 32'h80000000;
      end else begin
        cx_q[0] <= cx_pre;
        sy_q[0] <= sy_pre;
        z_q[0]  <= 32'h00000000;
      end
      // one micro-rotation per stage toward the x axis
      for (int i = 0; i < N; i++) begin
        if (sy_q[i] >= 0) begin
          cx_q[i+1] <= cx_q[i] + (sy_q[i] >>> i);
          sy_q[i+1] <= sy_q[i] - (cx_q[i] >>> i);
          z_q[i+1]  <= z_q[i] + atan_turn(i);
        end else begin
          cx_q[i+1] <= cx_q[i] - (sy_q[i] >>> i);
          sy_q[i+1] <= sy_q[i] + (cx_q[i] >>> i);
          z_q[i+1]  <= z_q[i] - atan_turn(i);
        end
      end
    end
  end

  assign ang_o = z_q[N];

endmodule

@@ rtl/tlfk_isqrt.sv @@
// pipelined integer square root rounded to nearest, clamped to the reach
`timescale 1ns / 1ps
module tlfk_isqrt (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [37:0] n_i,
  output logic [17:0] root_o
);
  import tlfk_pkg::*;

  localparam int unsigned N = 19;
  localparam int unsigned W = 39;

  logic [W-1:0] rem_q [1:N];
  logic [W-1:0] r_q   [1:N];
  logic [W-1:0] rem_s [0:N-1];
  logic [W-1:0] r_s   [0:N-1];
  logic [W-1:0] root_r;

  always_comb begin
    rem_s[0] = {1'b0, n_i};
    r_s[0]   = '0;
    for (int j = 1; j < N; j++) begin
      rem_s[j] = rem_q[j];
      r_s[j]   = r_q[j];
    end
  end

  // one result bit per stage, test bit walking down by powers of four
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < N; j++) begin
        if (rem_s[j] >= r_s[j] + (W'(1) << (2 * (N - 1 - j)))) begin
          rem_q[j+1] <= rem_s[j] - (r_s[j] + (W'(1) << (2 * (N - 1 - j))));
          r_q[j+1]   <= (r_s[j] >> 1) + (W'(1) << (2 * (N - 1 - j)));
        end else begin
          rem_q[j+1] <= rem_s[j];
          r_q[j+1]   <= r_s[j] >> 1;
        end
      end
    end
  end

  // round up when the remainder exceeds the root, then clamp
  always_comb begin
    root_r = (rem_q[N] > r_q[N]) ? r_q[N] + W'(1) : r_q[N];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      root_o <= (root_r > W'(ReachMax)) ? 18'(ReachMax) : root_r[17:0];
    end
  end

endmodule

@@ rtl/tlfk_div.sv @@
// pipelined rounded signed division for the pendulum rate, saturating to 16 bits
`timescale 1ns / 1ps
module tlfk_div (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [57:0] num_i,
  input  logic [37:0]        den_i,
  output logic signed [15:0] quo_o
);
  localparam int unsigned N = 16;
  localparam int unsigned W = 60;

  logic [W-1:0] mr_a_q;
  logic [37:0]  den_a_q;
  logic         neg_a_q;

  logic [W-1:0] rem_q [0:N];
  logic [37:0]  den_q [0:N];
  logic [15:0]  quo_q [0:N];
  logic         ovf_q [0:N];
  logic         neg_q [0:N];

  logic [57:0]  mag;

  assign mag = num_i[57] ? 58'(-num_i) : 58'(num_i);

  // magnitude plus half the divisor for round-to-nearest
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mr_a_q  <= W'(mag) + W'(den_i >> 1);
      den_a_q <= den_i;
      neg_a_q <= num_i[57];
    end
  end

  // range check, then one quotient bit per stage
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= mr_a_q;
      den_q[0] <= den_a_q;
      quo_q[0] <= '0;
      ovf_q[0] <= (mr_a_q >= (W'(den_a_q) << N));
      neg_q[0] <= neg_a_q;
      for (int s = 0; s < N; s++) begin
        den_q[s+1] <= den_q[s];
        ovf_q[s+1] <= ovf_q[s];
        neg_q[s+1] <= neg_q[s];
        if (rem_q[s] >= (W'(den_q[s]) << (N - 1 - s))) begin
          rem_q[s+1] <= rem_q[s] - (W'(den_q[s]) << (N - 1 - s));
          quo_q[s+1] <= quo_q[s] | (16'h0001 << (N - 1 - s));
        end else begin
          rem_q[s+1] <= rem_q[s];
          quo_q[s+1] <= quo_q[s];
        end
      end
    end
  end

  // saturate and apply the sign
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (neg_q[N]) begin
        quo_o <= (ovf_q[N] || quo_q[N] > 16'd32768) ? 16'sh8000 : 16'(-quo_q[N]);
      end else begin
        quo_o <= (ovf_q[N] || quo_q[N] > 16'd32767) ? 16'sh7FFF : quo_q[N];
      end
    end
  end

endmodule

@@ rtl/three_link_leg_forward_kinematics_unit.sv @@
// top level: planar three-link leg forward kinematics with foot and pendulum velocity
//
//  port group  | direction | handshake                 | payload
//  ------------+-----------+---------------------------+-------------------------------
//  joints in   | in        | in_valid_i / in_stall_o   | three angles, three rates
//  results out | out       | out_valid_o / out_stall_i | position, velocity, pendulum
//  apb config  | in/out    | psel penable pwrite pready| three link lengths at 0, 4, 8
//
// a request can enter every cycle while in_stall_o is low;
// the depth is set by the two 30-step cordic chains in series
// (sine/cosine, then pendulum angle) with the multiplies between them.
// the whole pipeline holds while a result is waiting and out_stall_i is high,
// so in_stall_o is high exactly then; bubbles travel as cleared valid bits.
// reset clears the valid bits and the link lengths; no clearing pass.
`timescale 1ns / 1ps
module three_link_leg_forward_kinematics_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] hip_angle_i,
  input  logic signed [15:0] knee_angle_i,
  input  logic signed [15:0] ankle_angle_i,
  input  logic signed [15:0] hip_rate_i,
  input  logic signed [15:0] knee_rate_i,
  input  logic signed [15:0] ankle_rate_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [18:0] foot_x_o,
  output logic signed [18:0] foot_y_o,
  output logic [17:0]        pendulum_length_o,
  output logic signed [15:0] pendulum_angle_o,
  output logic signed [23:0] foot_vel_x_o,
  output logic signed [23:0] foot_vel_y_o,
  output logic signed [15:0] pendulum_rate_o,
  output logic               zero_length_o
);
  import tlfk_pkg::*;

  typedef enum logic [1:0] {
    REG_THIGH = 2'd0,
    REG_CALF  = 2'd1,
    REG_FOOT  = 2'd2
  } reg_idx_e;

  localparam int unsigned Lat = 67;

  logic        en;
  logic        vld_q [0:Lat];
  logic [15:0] thigh_q, calf_q, foot_q;
  reg_idx_e    reg_idx;

  // configuration port
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thigh_q <= '0;
      calf_q  <= '0;
      foot_q  <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_THIGH: thigh_q <= pwdata[15:0];
        REG_CALF:  calf_q  <= pwdata[15:0];
        REG_FOOT:  foot_q  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_THIGH: prdata = {16'h0000, thigh_q};
      REG_CALF:  prdata = {16'h0000, calf_q};
      REG_FOOT:  prdata = {16'h0000, foot_q};
      default:   prdata = '0;
    endcase
  end

  // pipeline advance and valid bits
  assign en          = !(vld_q[Lat] && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = vld_q[Lat];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= Lat; k++) vld_q[k] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= in_valid_i;
      for (int k = 1; k <= Lat; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  // stage 0: cumulative link angles and rates
  logic [15:0] a1_q, a2_q, a3_q;
  rates_t      rt_q [0:33];

  always_ff @(posedge clk_i) begin
    if (en) begin
      a1_q     <= hip_angle_i;
      a2_q     <= hip_angle_i + knee_angle_i;
      a3_q     <= hip_angle_i + knee_angle_i + ankle_angle_i;
      rt_q[0]  <= '{hr: hip_rate_i, kr: knee_rate_i, ar: ankle_rate_i};
      for (int k = 1; k <= 33; k++) rt_q[k] <= rt_q[k-1];
    end
  end

  // stages 1-31: sine and cosine of each link
  logic signed [32:0] sn1, cs1, sn2, cs2, sn3, cs3;

  tlfk_sincos u_sc1 (.clk_i(clk_i), .en_i(en), .ang_i(a1_q), .sin_o(sn1), .cos_o(cs1));
  tlfk_sincos u_sc2 (.clk_i(clk_i), .en_i(en), .ang_i(a2_q), .sin_o(sn2), .cos_o(cs2));
  tlfk_sincos u_sc3 (.clk_i(clk_i), .en_i(en), .ang_i(a3_q), .sin_o(sn3), .cos_o(cs3));

  // stage 32: link length times sine and cosine
  logic signed [49:0] ps1_q, pc1_q, ps2_q, pc2_q, ps3_q, pc3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ps1_q <= $signed({1'b0, thigh_q}) * sn1;
      pc1_q <= $signed({1'b0, thigh_q}) * cs1;
      ps2_q <= $signed({1'b0, calf_q}) * sn2;
      pc2_q <= $signed({1'b0, calf_q}) * cs2;
      ps3_q <= $signed({1'b0, foot_q}) * sn3;
      pc3_q <= $signed({1'b0, foot_q}) * cs3;
    end
  end

  // stage 33: round each term and form position and partial sums
  localparam logic signed [49:0] Half30 = 50'sh0000020000000;

  logic signed [19:0] s1r, c1r, s2r, c2r, s3r, c3r;
  logic signed [19:0] x33_q, y33_q, s23_q, c23_q, s3_q, c3_q;

  always_comb begin
    s1r = 20'((ps1_q + Half30) >>> 30);
    c1r = 20'((pc1_q + Half30) >>> 30);
    s2r = 20'((ps2_q + Half30) >>> 30);
    c2r = 20'((pc2_q + Half30) >>> 30);
    s3r = 20'((ps3_q + Half30) >>> 30);
    c3r = 20'((pc3_q + Half30) >>> 30);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x33_q <= s1r + s2r + s3r;
      y33_q <= c1r + c2r + c3r;
      s23_q <= s2r + s3r;
      c23_q <= c2r + c3r;
      s3_q  <= s3r;
      c3_q  <= c3r;
    end
  end

  // stage 34: jacobian products
  logic signed [35:0] vx0_q, vx1_q, vx2_q, vy0_q, vy1_q, vy2_q;
  logic signed [19:0] x34_q, y34_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      vx0_q <= y33_q * rt_q[33].hr;
      vx1_q <= c23_q * rt_q[33].kr;
      vx2_q <= c3_q  * rt_q[33].ar;
      vy0_q <= x33_q * rt_q[33].hr;
      vy1_q <= s23_q * rt_q[33].kr;
      vy2_q <= s3_q  * rt_q[33].ar;
      x34_q <= x33_q;
      y34_q <= y33_q;
    end
  end

  // stage 35: foot velocity in 2^-26 m/s
  logic signed [37:0] vx35_q, vy35_q;
  logic signed [19:0] x35_q, y35_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      vx35_q <= 38'(vx0_q) + 38'(vx1_q) + 38'(vx2_q);
      vy35_q <= -(38'(vy0_q) + 38'(vy1_q) + 38'(vy2_q));
      x35_q  <= x34_q;
      y35_q  <= y34_q;
    end
  end

  // stage 36: squares, split rate numerator products, output clamps
  localparam logic signed [19:0] ReachPos = 20'sd196608;
  localparam logic signed [19:0] ReachNeg = -20'sd196608;
  localparam logic signed [37:0] Half16   = 38'sd32768;

  logic signed [39:0] xx_q, yy_q, yvl_q, xvl_q;
  logic signed [38:0] yvh_q, xvh_q;
  logic signed [37:0] vxr, vyr;
  kin_t               kin_q [36:66];

  always_comb begin
    vxr = (vx35_q + Half16) >>> 16;
    vyr = (vy35_q + Half16) >>> 16;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      xx_q  <= x35_q * x35_q;
      yy_q  <= y35_q * y35_q;
      yvl_q <= y35_q * $signed({1'b0, vx35_q[18:0]});
      xvl_q <= x35_q * $signed({1'b0, vy35_q[18:0]});
      yvh_q <= y35_q * $signed(vx35_q[37:19]);
      xvh_q <= x35_q * $signed(vy35_q[37:19]);
      kin_q[36].fx   <= 19'((x35_q > ReachPos) ? ReachPos :
                            ((x35_q < ReachNeg) ? ReachNeg : x35_q));
      kin_q[36].fy   <= 19'((y35_q > ReachPos) ? ReachPos :
                            ((y35_q < ReachNeg) ? ReachNeg : y35_q));
      kin_q[36].vx   <= 24'(vxr);
      kin_q[36].vy   <= 24'(vyr);
      kin_q[36].zero <= (x35_q == '0) && (y35_q == '0);
      for (int k = 37; k <= 66; k++) kin_q[k] <= kin_q[k-1];
    end
  end

  // stage 37: squared length and rate numerator
  logic [37:0]        n_q;
  logic signed [57:0] num_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      n_q   <= xx_q[37:0] + yy_q[37:0];
      num_q <= ((58'(yvh_q) - 58'(xvh_q)) <<< 19) + (58'(yvl_q) - 58'(xvl_q));
    end
  end

  // slow branches: pendulum angle, length and rate
  logic [31:0]        pang;
  logic [17:0]        plen;
  logic signed [15:0] prate;

  tlfk_vector u_vec (.clk_i(clk_i), .en_i(en), .cos_i(y35_q), .sin_i(x35_q), .ang_o(pang));
  tlfk_isqrt  u_sqrt (.clk_i(clk_i), .en_i(en), .n_i(n_q), .root_o(plen));
  tlfk_div    u_div (.clk_i(clk_i), .en_i(en), .num_i(num_q), .den_i(n_q), .quo_o(prate));

  // align length and rate with the angle branch
  logic [17:0]        plen_q [58:66];
  logic signed [15:0] prate_q [57:66];

  always_ff @(posedge clk_i) begin
    if (en) begin
      plen_q[58]  <= plen;
      prate_q[57] <= prate;
      for (int k = 59; k <= 66; k++) plen_q[k] <= plen_q[k-1];
      for (int k = 58; k <= 66; k++) prate_q[k] <= prate_q[k-1];
    end
  end

  // output register
  logic [31:0] pang_r;

  assign pang_r = pang + 32'h00008000;

  always_ff @(posedge clk_i) begin
    if (en) begin
      foot_x_o          <= kin_q[66].fx;
      foot_y_o          <= kin_q[66].fy;
      foot_vel_x_o      <= kin_q[66].vx;
      foot_vel_y_o      <= kin_q[66].vy;
      zero_length_o     <= kin_q[66].zero;
      pendulum_length_o <= plen_q[66];
      pendulum_angle_o  <= kin_q[66].zero ? 16'sd0 : pang_r[31:16];
      pendulum_rate_o   <= kin_q[66].zero ? 16'sd0 : prate_q[66];
    end
  end

  // checks
  a_zero_forces: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_length_o |-> pendulum_rate_o == 16'sd0 && pendulum_angle_o == 16'sd0)
    else $error("zero length without forced angle and rate");

  a_zero_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_length_o |-> pendulum_length_o == 18'd0)
    else $error("zero flag with nonzero pendulum length");

  a_len_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pendulum_length_o <= 18'(ReachMax))
    else $error("pendulum length beyond reach");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> foot_x_o >= -19'sd196608 && foot_x_o <= 19'sd196608
                    && foot_y_o >= -19'sd196608 && foot_y_o <= 19'sd196608)
    else $error("foot position outside clamp range");

endmodule
